/* rtl/i2cte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine package
// Shared widths, event codes and configuration register indexes.
// ----------------------------------------------------------------------------
package i2cte_pkg;

	localparam int ADDR_W      = 7;
	localparam int DEV_COUNT_W = 3;
	localparam int LIMIT_W     = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int BYTE_W      = 8;
	localparam int SLOT_OUT_W  = 2;
	localparam int EVENT_W     = 3;

	// Stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// Number of address slot registers in the register map
	localparam int CFG_SLOT_REGS = 4;

	localparam logic [LIMIT_W-1:0] STUCK_LOW_RESET = 20'd250000;
	localparam logic [LIMIT_W-1:0] NO_EDGE_RESET   = 20'd1000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_COUNT   = 3'd0,
		CFG_ADDRESS_SLOT_0 = 3'd1,
		CFG_ADDRESS_SLOT_1 = 3'd2,
		CFG_ADDRESS_SLOT_2 = 3'd3,
		CFG_ADDRESS_SLOT_3 = 3'd4,
		CFG_STUCK_LOW      = 3'd5,
		CFG_NO_EDGE        = 3'd6
	} cfg_index_t;

	typedef enum logic [EVENT_W-1:0] {
		DEV_NONE    = 3'd0,
		DEV_BEGIN   = 3'd1,
		DEV_RECEIVE = 3'd2,
		DEV_FETCH   = 3'd3,
		DEV_ADVANCE = 3'd4,
		DEV_END     = 3'd5
	} dev_event_t;

	typedef enum logic [EVENT_W-1:0] {
		BUS_NONE    = 3'd0,
		BUS_START   = 3'd1,
		BUS_RESTART = 3'd2,
		BUS_STOP    = 3'd3,
		BUS_TIMEOUT = 3'd4
	} bus_event_t;

endpackage

/* rtl/i2cte_addr_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target address matcher
// Compares a received 7-bit address against the enabled slots; the lowest
// matching slot wins.
// ----------------------------------------------------------------------------
module i2cte_addr_match
	import i2cte_pkg::*;
#(
	parameter int NUM_SLOTS = 4,
	parameter int SLOT_W    = 2
) (
	input  logic [ADDR_W-1:0]                 addr,
	input  logic [DEV_COUNT_W-1:0]            dev_count,
	input  logic [NUM_SLOTS-1:0][ADDR_W-1:0]  slot_addr,
	output logic                              hit,
	output logic [SLOT_W-1:0]                 slot
);

	always_comb begin
		hit  = 1'b0;
		slot = '0;
		// scan from the top so the lowest match overrides
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (i < int'(dev_count) && slot_addr[i] == addr) begin
				hit  = 1'b1;
				slot = SLOT_W'(i);
			end
		end
	end

endmodule

/* rtl/i2c_target_bit_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine
// Per-sample I2C target: START/STOP detection, address match, ACK, byte
// receive and transmit, bus timeouts, backend and bus event reporting.
// ----------------------------------------------------------------------------
// Output: the result item for a sample appears in the cycle after the sample is
//   accepted, from the output register.
// Throughput: one item per cycle; a new sample is taken in the same cycle the
//   previous result leaves, and a result held by m_axis_tready low blocks the
//   input until it drains.
// Reset: arst_n clears the bus phase to idle with SDA released, the line
//   history to high, and the registers to their defaults (no slots enabled).
// ----------------------------------------------------------------------------
module i2c_target_bit_engine
	import i2cte_pkg::*;
#(
	parameter int NUM_SLOTS     = 4,
	parameter int TIMEOUT_WIDTH = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// Configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,

	// Line samples in
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// scl_in[0], sda_in[1], byte_accept[2], read_data[10:3], zero[15:11]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

	// Results out
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// sda_pull_low[0], device_event[3:1], device_slot[5:4], event_data[13:6],
	// bus_event[16:14], zero[23:17]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CMP_W  = (TIMEOUT_WIDTH > LIMIT_W) ? TIMEOUT_WIDTH : LIMIT_W;
	localparam logic [TIMEOUT_WIDTH-1:0] IDLE_MAX = {TIMEOUT_WIDTH{1'b1}};

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ADDR     = 3'd1,
		PH_ADDR_ACK = 3'd2,
		PH_RX       = 3'd3,
		PH_RX_ACK   = 3'd4,
		PH_TX       = 3'd5,
		PH_TX_ACK   = 3'd6,
		PH_IGNORE   = 3'd7
	} phase_t;

	// ACK bit sequencing: wait for falling edge, drive, sample on rising, release
	localparam logic [1:0] ACK_WAIT   = 2'd0;
	localparam logic [1:0] ACK_DRIVEN = 2'd1;
	localparam logic [1:0] ACK_DONE   = 2'd2;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DEV_COUNT_W-1:0]           dev_count_q;
	logic [NUM_SLOTS-1:0][ADDR_W-1:0] slot_addr_q;
	logic [LIMIT_W-1:0]               stuck_low_limit_q;
	logic [LIMIT_W-1:0]               no_edge_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q       <= '0;
			slot_addr_q       <= '0;
			stuck_low_limit_q <= STUCK_LOW_RESET;
			no_edge_limit_q   <= NO_EDGE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEVICE_COUNT)
				dev_count_q <= cfg_wdata[DEV_COUNT_W-1:0];
			if (cfg_index == CFG_STUCK_LOW)
				stuck_low_limit_q <= cfg_wdata[LIMIT_W-1:0];
			if (cfg_index == CFG_NO_EDGE)
				no_edge_limit_q <= cfg_wdata[LIMIT_W-1:0];
			// only the first four slots have registers; higher slots stay zero
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (i < CFG_SLOT_REGS &&
				    cfg_index == CFG_IDX_W'(int'(CFG_ADDRESS_SLOT_0) + i))
					slot_addr_q[i] <= cfg_wdata[ADDR_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Engine state
	// ------------------------------------------------------------------
	phase_t                   phase_q, nxt_phase;
	logic [BYTE_W-1:0]        rx_shift_q, nxt_rx_shift;
	logic [3:0]               rx_cnt_q, nxt_rx_cnt;
	logic [BYTE_W-1:0]        tx_shift_q, nxt_tx_shift;
	logic [3:0]               tx_cnt_q, nxt_tx_cnt;
	logic [1:0]               ack_step_q, nxt_ack_step;
	logic                     matched_q, nxt_matched;
	logic [SLOT_W-1:0]        active_slot_q, nxt_active_slot;
	logic                     is_read_q, nxt_is_read;
	logic                     pending_accept_q, nxt_pending_accept;
	logic                     master_acked_q, nxt_master_acked;
	logic                     last_scl_q, last_sda_q;
	logic [TIMEOUT_WIDTH-1:0] idle_cnt_q, nxt_idle_cnt;
	logic                     drive_low_q, nxt_drive_low;

	// Unpacked input item
	logic              scl, sda, acc;
	logic [BYTE_W-1:0] rd;
	assign scl = s_axis_tdata[0];
	assign sda = s_axis_tdata[1];
	assign acc = s_axis_tdata[2];
	assign rd  = s_axis_tdata[10:3];

	// Address match on the byte completed by this rising edge: the address is
	// the old shift register's low seven bits, the direction is this SDA.
	logic              addr_hit;
	logic [SLOT_W-1:0] addr_slot;

	i2cte_addr_match #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_addr_match (
		.addr      (rx_shift_q[ADDR_W-1:0]),
		.dev_count (dev_count_q),
		.slot_addr (slot_addr_q),
		.hit       (addr_hit),
		.slot      (addr_slot)
	);

	// Result of this sample
	dev_event_t        o_dev;
	logic [SLOT_W-1:0] o_slot;
	logic [BYTE_W-1:0] o_data;
	bus_event_t        o_bev;

	logic [TIMEOUT_WIDTH-1:0] idle_inc;
	logic                     timed_out;
	logic [BYTE_W-1:0]        rx_next;

	assign idle_inc = (idle_cnt_q != IDLE_MAX) ? idle_cnt_q + 1'b1 : idle_cnt_q;
	assign timed_out =
		(!scl && !sda && CMP_W'(idle_inc) > CMP_W'(stuck_low_limit_q)) ||
		(CMP_W'(idle_inc) > CMP_W'(no_edge_limit_q));
	assign rx_next = {rx_shift_q[BYTE_W-2:0], sda};

	always_comb begin
		nxt_phase          = phase_q;
		nxt_rx_shift       = rx_shift_q;
		nxt_rx_cnt         = rx_cnt_q;
		nxt_tx_shift       = tx_shift_q;
		nxt_tx_cnt         = tx_cnt_q;
		nxt_ack_step       = ack_step_q;
		nxt_matched        = matched_q;
		nxt_active_slot    = active_slot_q;
		nxt_is_read        = is_read_q;
		nxt_pending_accept = pending_accept_q;
		nxt_master_acked   = master_acked_q;
		nxt_idle_cnt       = idle_cnt_q;
		nxt_drive_low      = drive_low_q;
		o_dev              = DEV_NONE;
		o_slot             = '0;
		o_data             = '0;
		o_bev              = BUS_NONE;

		if (phase_q == PH_IDLE) begin
			// only a START leaves idle; no timeout runs here
			if (last_sda_q && !sda && scl) begin
				nxt_phase          = PH_ADDR;
				nxt_rx_shift       = '0;
				nxt_rx_cnt         = '0;
				nxt_ack_step       = ACK_WAIT;
				nxt_matched        = 1'b0;
				nxt_is_read        = 1'b0;
				nxt_pending_accept = 1'b1;
				nxt_drive_low      = 1'b0;
				nxt_idle_cnt       = '0;
				o_bev              = BUS_START;
			end
		end else if (scl == last_scl_q && sda == last_sda_q) begin
			// bus unchanged: advance the stall counter, saturating
			nxt_idle_cnt = idle_inc;
			if (timed_out) begin
				if (matched_q) begin
					o_dev  = DEV_END;
					o_slot = active_slot_q;
				end
				nxt_matched   = 1'b0;
				nxt_drive_low = 1'b0;
				nxt_phase     = PH_IDLE;
				nxt_idle_cnt  = '0;
				o_bev         = BUS_TIMEOUT;
			end
		end else begin
			nxt_idle_cnt = '0;
			if (scl && last_sda_q && !sda) begin
				// repeated START: close the device, restart address phase
				if (matched_q) begin
					o_dev  = DEV_END;
					o_slot = active_slot_q;
				end
				nxt_phase          = PH_ADDR;
				nxt_rx_shift       = '0;
				nxt_rx_cnt         = '0;
				nxt_ack_step       = ACK_WAIT;
				nxt_matched        = 1'b0;
				nxt_is_read        = 1'b0;
				nxt_pending_accept = 1'b1;
				nxt_drive_low      = 1'b0;
				o_bev              = BUS_RESTART;
			end else if (scl && !last_sda_q && sda) begin
				// STOP
				if (matched_q) begin
					o_dev  = DEV_END;
					o_slot = active_slot_q;
				end
				nxt_matched   = 1'b0;
				nxt_drive_low = 1'b0;
				nxt_phase     = PH_IDLE;
				o_bev         = BUS_STOP;
			end else if (!last_scl_q && scl) begin
				// SCL rising: sample data
				unique case (phase_q)
					PH_ADDR: begin
						nxt_rx_shift = rx_next;
						nxt_rx_cnt   = rx_cnt_q + 1'b1;
						if (rx_cnt_q >= 4'd7) begin
							nxt_is_read  = sda;
							nxt_matched  = addr_hit;
							nxt_ack_step = ACK_WAIT;
							nxt_phase    = PH_ADDR_ACK;
							if (addr_hit) begin
								nxt_active_slot = addr_slot;
								o_dev           = DEV_BEGIN;
								o_slot          = addr_slot;
								o_data          = BYTE_W'(sda);
							end
						end
					end
					PH_ADDR_ACK, PH_RX_ACK: begin
						if (ack_step_q == ACK_DRIVEN)
							nxt_ack_step = ACK_DONE;
					end
					PH_RX: begin
						nxt_rx_shift = rx_next;
						nxt_rx_cnt   = rx_cnt_q + 1'b1;
						if (rx_cnt_q >= 4'd7) begin
							nxt_pending_accept = acc;
							o_dev              = DEV_RECEIVE;
							o_slot             = active_slot_q;
							o_data             = rx_next;
							nxt_ack_step       = ACK_WAIT;
							nxt_phase          = PH_RX_ACK;
						end
					end
					PH_TX: begin
						nxt_tx_cnt = tx_cnt_q + 1'b1;
						if (tx_cnt_q >= 4'd7) begin
							nxt_ack_step = ACK_WAIT;
							nxt_phase    = PH_TX_ACK;
						end
					end
					PH_TX_ACK: begin
						if (ack_step_q == ACK_DRIVEN) begin
							nxt_master_acked = !sda;
							nxt_ack_step     = ACK_DONE;
							o_dev            = DEV_ADVANCE;
							o_slot           = active_slot_q;
							o_data           = BYTE_W'(!sda);
						end
					end
					default: ;
				endcase
			end else if (last_scl_q && !scl) begin
				// SCL falling: set up the next data or ACK bit
				unique case (phase_q)
					PH_ADDR_ACK: begin
						if (ack_step_q == ACK_WAIT) begin
							nxt_drive_low = matched_q;
							nxt_ack_step  = ACK_DRIVEN;
						end else if (ack_step_q == ACK_DONE) begin
							nxt_drive_low = 1'b0;
							nxt_ack_step  = ACK_WAIT;
							if (!matched_q) begin
								nxt_phase = PH_IGNORE;
							end else if (is_read_q) begin
								nxt_tx_shift  = rd;
								nxt_tx_cnt    = '0;
								nxt_drive_low = !rd[BYTE_W-1];
								nxt_phase     = PH_TX;
								o_dev         = DEV_FETCH;
								o_slot        = active_slot_q;
							end else begin
								nxt_rx_shift = '0;
								nxt_rx_cnt   = '0;
								nxt_phase    = PH_RX;
							end
						end
					end
					PH_RX_ACK: begin
						if (ack_step_q == ACK_WAIT) begin
							nxt_drive_low = pending_accept_q;
							nxt_ack_step  = ACK_DRIVEN;
						end else if (ack_step_q == ACK_DONE) begin
							nxt_drive_low = 1'b0;
							nxt_ack_step  = ACK_WAIT;
							nxt_rx_shift  = '0;
							nxt_rx_cnt    = '0;
							nxt_phase     = pending_accept_q ? PH_RX : PH_IGNORE;
						end
					end
					PH_TX: begin
						// MSB first; bit index is seven minus the count
						if (!tx_cnt_q[3])
							nxt_drive_low = !tx_shift_q[~tx_cnt_q[2:0]];
					end
					PH_TX_ACK: begin
						if (ack_step_q == ACK_WAIT) begin
							nxt_drive_low = 1'b0;
							nxt_ack_step  = ACK_DRIVEN;
						end else if (ack_step_q == ACK_DONE) begin
							nxt_ack_step = ACK_WAIT;
							if (master_acked_q) begin
								nxt_tx_shift  = rd;
								nxt_tx_cnt    = '0;
								nxt_drive_low = !rd[BYTE_W-1];
								nxt_phase     = PH_TX;
								o_dev         = DEV_FETCH;
								o_slot        = active_slot_q;
							end else begin
								nxt_drive_low = 1'b0;
								nxt_phase     = PH_IGNORE;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Handshake and registers
	// ------------------------------------------------------------------
	logic                  out_valid_q;
	logic                  in_take;
	logic [31:0]           slot_ext;
	logic [OUT_TDATA_W-1:0] result;

	// take a sample whenever the result register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	assign slot_ext = 32'(o_slot);
	assign result = {7'd0, o_bev, o_data, slot_ext[SLOT_OUT_W-1:0], o_dev,
	                 nxt_drive_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			rx_shift_q       <= '0;
			rx_cnt_q         <= '0;
			tx_shift_q       <= '0;
			tx_cnt_q         <= '0;
			ack_step_q       <= ACK_WAIT;
			matched_q        <= 1'b0;
			active_slot_q    <= '0;
			is_read_q        <= 1'b0;
			pending_accept_q <= 1'b1;
			master_acked_q   <= 1'b0;
			last_scl_q       <= 1'b1;
			last_sda_q       <= 1'b1;
			idle_cnt_q       <= '0;
			drive_low_q      <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (in_take) begin
				phase_q          <= nxt_phase;
				rx_shift_q       <= nxt_rx_shift;
				rx_cnt_q         <= nxt_rx_cnt;
				tx_shift_q       <= nxt_tx_shift;
				tx_cnt_q         <= nxt_tx_cnt;
				ack_step_q       <= nxt_ack_step;
				matched_q        <= nxt_matched;
				active_slot_q    <= nxt_active_slot;
				is_read_q        <= nxt_is_read;
				pending_accept_q <= nxt_pending_accept;
				master_acked_q   <= nxt_master_acked;
				last_scl_q       <= scl;
				last_sda_q       <= sda;
				idle_cnt_q       <= nxt_idle_cnt;
				drive_low_q      <= nxt_drive_low;
				out_valid_q      <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on every accepted sample, hold otherwise
	logic [OUT_TDATA_W-1:0] result_q;

	always_ff @(posedge clk) begin
		if (in_take)
			result_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Every accepted sample yields a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
	else $error("accepted sample produced no result");

	// A result appears only after a sample was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
	else $error("result appeared without an accepted sample");

	// The data line is never held low once the engine is back in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !drive_low_q)
	else $error("SDA pulled low while idle");

	// Transmit is entered only through a byte fetch, which clears the ACK step
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TX |-> ack_step_q == ACK_WAIT)
	else $error("ACK step left over in transmit phase");

endmodule

/* verif/i2c_target_bit_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine testbench
// Feeds SCL/SDA line samples built from well-formed bus transfers, aborted
// transfers and line noise. Each sample carries a random backend accept bit
// and read byte. An in-bench model of the engine predicts one result item per
// sample, and every result is checked field by field. Both streams idle at
// random. Registers are rewritten between phases, covering slot counts
// including clamped ones, duplicate and extreme addresses, the stuck limit
// from zero to the maximum and the no-edge limit from two to the maximum.
// ----------------------------------------------------------------------------
module i2c_target_bit_engine_tb;
	import i2cte_pkg::*;

	// Index with no register behind it; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
	localparam logic [LIMIT_W-1:0]   LIMIT_MAX     = '1;

	// ACK bit steps: wait for falling edge, driven, sampled
	localparam logic [1:0] STEP_WAIT   = 2'd0;
	localparam logic [1:0] STEP_DRIVEN = 2'd1;
	localparam logic [1:0] STEP_DONE   = 2'd2;

	// Input sample, last field in the lowest bit
	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              byte_accept;
		logic              sda;
		logic              scl;
	} line_sample_t;

	// Result item, last field in the lowest bit
	typedef struct packed {
		bus_event_t             bus;
		logic [BYTE_W-1:0]      data;
		logic [SLOT_OUT_W-1:0]  slot;
		dev_event_t             dev;
		logic                   pull;
	} result_t;

	typedef enum logic [2:0] {
		P_IDLE, P_ADDR, P_ADDR_ACK, P_RX, P_DATA_ACK, P_TX, P_TX_ACK, P_SKIP
	} bus_phase_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	i2c_target_bit_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Run limit, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Engine model: register copies and bus state
	// ------------------------------------------------------------------------
	logic [DEV_COUNT_W-1:0] slots_used;
	logic [ADDR_W-1:0]      slot_addr [CFG_SLOT_REGS];
	logic [LIMIT_W-1:0]     stuck_limit;
	logic [LIMIT_W-1:0]     quiet_limit;

	bus_phase_t         phase;
	logic [BYTE_W-1:0]  rx_byte;
	logic [3:0]         rx_bits;
	logic [BYTE_W-1:0]  tx_byte;
	logic [3:0]         tx_bits;
	logic [1:0]         ack_step;
	logic               addressed;
	logic [1:0]         cur_slot;
	logic               is_read;
	logic               accept_held;
	logic               host_acked;
	logic               prev_scl;
	logic               prev_sda;
	logic [LIMIT_W-1:0] quiet_count;
	logic               pull_low;
	result_t            line_result;

	function automatic void reset_engine_model();
		slots_used  = '0;
		foreach (slot_addr[i])
			slot_addr[i] = '0;
		stuck_limit = STUCK_LOW_RESET;
		quiet_limit = NO_EDGE_RESET;
		phase       = P_IDLE;
		rx_byte     = '0;
		rx_bits     = '0;
		tx_byte     = '0;
		tx_bits     = '0;
		ack_step    = STEP_WAIT;
		addressed   = 1'b0;
		cur_slot    = '0;
		is_read     = 1'b0;
		accept_held = 1'b1;
		host_acked  = 1'b0;
		prev_scl    = 1'b1;
		prev_sda    = 1'b1;
		quiet_count = '0;
		pull_low    = 1'b0;
	endfunction

	// Report the end of the addressed device, if any, and drop the match
	function automatic void close_device();
		if (addressed) begin
			line_result.dev  = DEV_END;
			line_result.slot = cur_slot;
			line_result.data = '0;
		end
		addressed = 1'b0;
	endfunction

	function automatic void open_address();
		phase       = P_ADDR;
		rx_byte     = '0;
		rx_bits     = '0;
		ack_step    = STEP_WAIT;
		addressed   = 1'b0;
		is_read     = 1'b0;
		accept_held = 1'b1;
		pull_low    = 1'b0;
	endfunction

	// Take the next read byte and put its MSB on the line
	function automatic void load_tx(input logic [BYTE_W-1:0] rd);
		tx_byte          = rd;
		tx_bits          = '0;
		pull_low         = ~rd[7];
		phase            = P_TX;
		line_result.dev  = DEV_FETCH;
		line_result.slot = cur_slot;
		line_result.data = '0;
	endfunction

	function automatic void clock_rise(input logic sda, input logic acc);
		int n;
		n = (slots_used > CFG_SLOT_REGS) ? CFG_SLOT_REGS : int'(slots_used);
		case (phase)
			P_ADDR: begin
				rx_byte = {rx_byte[6:0], sda};
				rx_bits++;
				if (rx_bits >= 8) begin
					is_read   = rx_byte[0];
					addressed = 1'b0;
					// lowest matching slot wins
					for (int i = 0; i < n; i++) begin
						if (!addressed && slot_addr[i] == rx_byte[7:1]) begin
							addressed = 1'b1;
							cur_slot  = i[1:0];
						end
					end
					if (addressed) begin
						line_result.dev  = DEV_BEGIN;
						line_result.slot = cur_slot;
						line_result.data = {7'd0, is_read};
					end
					ack_step = STEP_WAIT;
					phase    = P_ADDR_ACK;
				end
			end
			P_ADDR_ACK, P_DATA_ACK: begin
				if (ack_step == STEP_DRIVEN)
					ack_step = STEP_DONE;
			end
			P_RX: begin
				rx_byte = {rx_byte[6:0], sda};
				rx_bits++;
				if (rx_bits >= 8) begin
					accept_held      = acc;
					line_result.dev  = DEV_RECEIVE;
					line_result.slot = cur_slot;
					line_result.data = rx_byte;
					ack_step         = STEP_WAIT;
					phase            = P_DATA_ACK;
				end
			end
			P_TX: begin
				tx_bits++;
				if (tx_bits >= 8) begin
					ack_step = STEP_WAIT;
					phase    = P_TX_ACK;
				end
			end
			P_TX_ACK: begin
				if (ack_step == STEP_DRIVEN) begin
					host_acked       = ~sda;
					ack_step         = STEP_DONE;
					line_result.dev  = DEV_ADVANCE;
					line_result.slot = cur_slot;
					line_result.data = {7'd0, host_acked};
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void clock_fall(input logic [BYTE_W-1:0] rd);
		case (phase)
			P_ADDR_ACK: begin
				if (ack_step == STEP_WAIT) begin
					pull_low = addressed;
					ack_step = STEP_DRIVEN;
				end else if (ack_step == STEP_DONE) begin
					pull_low = 1'b0;
					ack_step = STEP_WAIT;
					if (!addressed) begin
						phase = P_SKIP;
					end else if (is_read) begin
						load_tx(rd);
					end else begin
						rx_byte = '0;
						rx_bits = '0;
						phase   = P_RX;
					end
				end
			end
			P_DATA_ACK: begin
				if (ack_step == STEP_WAIT) begin
					pull_low = accept_held;
					ack_step = STEP_DRIVEN;
				end else if (ack_step == STEP_DONE) begin
					pull_low = 1'b0;
					ack_step = STEP_WAIT;
					rx_byte  = '0;
					rx_bits  = '0;
					phase    = accept_held ? P_RX : P_SKIP;
				end
			end
			P_TX: begin
				if (tx_bits < 8)
					pull_low = ~tx_byte[3'd7 - tx_bits[2:0]];
			end
			P_TX_ACK: begin
				if (ack_step == STEP_WAIT) begin
					pull_low = 1'b0;
					ack_step = STEP_DRIVEN;
				end else if (ack_step == STEP_DONE) begin
					ack_step = STEP_WAIT;
					if (host_acked) begin
						load_tx(rd);
					end else begin
						pull_low = 1'b0;
						phase    = P_SKIP;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the model by one line sample and return its result item
	function automatic result_t predict_line_result(input line_sample_t s);
		line_result     = '0;
		line_result.bus = BUS_NONE;
		if (phase == P_IDLE) begin
			// only a START leaves idle; nothing times out here
			if (prev_sda && !s.sda && s.scl) begin
				open_address();
				quiet_count     = '0;
				line_result.bus = BUS_START;
			end
		end else if (s.scl == prev_scl && s.sda == prev_sda) begin
			if (quiet_count != LIMIT_MAX)
				quiet_count++;
			if ((!s.scl && !s.sda && quiet_count > stuck_limit) ||
					quiet_count > quiet_limit) begin
				close_device();
				pull_low        = 1'b0;
				phase           = P_IDLE;
				quiet_count     = '0;
				line_result.bus = BUS_TIMEOUT;
			end
		end else begin
			quiet_count = '0;
			// START and STOP win over clock edges in the same sample
			if (s.scl && prev_sda && !s.sda) begin
				close_device();
				open_address();
				line_result.bus = BUS_RESTART;
			end else if (s.scl && !prev_sda && s.sda) begin
				close_device();
				pull_low        = 1'b0;
				phase           = P_IDLE;
				line_result.bus = BUS_STOP;
			end else begin
				if (!prev_scl && s.scl)
					clock_rise(s.sda, s.byte_accept);
				if (prev_scl && !s.scl)
					clock_fall(s.read_data);
			end
		end
		prev_scl         = s.scl;
		prev_sda         = s.sda;
		line_result.pull = pull_low;
		return line_result;
	endfunction

	// ------------------------------------------------------------------------
	// Idle patterns shared by both stream sides
	// ------------------------------------------------------------------------
	logic calm = 1'b0;
	int   calm_left = 0;

	// Alternate stretches of back-to-back traffic with stretches of random gaps
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm      = ~calm;
			calm_left = $urandom_range(20, 200);
		end else begin
			calm_left--;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Sample driver: pops pending samples, changes inputs on the falling edge
	// ------------------------------------------------------------------------
	line_sample_t sample_queue[$];
	logic         in_taken = 1'b0;
	int           in_gap = 0;
	int           out_gap = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_queue.size() > 0) begin
				s_axis_tdata  <= IN_TDATA_W'(sample_queue.pop_front());
				s_axis_tvalid <= 1'b1;
				in_gap = calm ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 2) == 0)
				out_gap = pick_gap();
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on each accepted sample, check each accepted result
	// ------------------------------------------------------------------------
	result_t expected_results[$];
	int      errors = 0;
	int      results_checked = 0;
	int      bus_seen [8];
	int      dev_seen [8];

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			in_taken = s_axis_tvalid && s_axis_tready;
			// push before popping: the result leaves in a later cycle than its sample
			if (in_taken)
				expected_results.push_back(predict_line_result(
					line_sample_t'(s_axis_tdata[$bits(line_sample_t)-1:0])));
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result %0h arrived with nothing expected", $time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("sda_pull_low", want.pull, got.pull);
					check_field("device_event", want.dev, got.dev);
					check_field("device_slot", want.slot, got.slot);
					check_field("event_data", want.data, got.data);
					check_field("bus_event", want.bus, got.bus);
					results_checked++;
					bus_seen[got.bus]++;
					dev_seen[got.dev]++;
				end
			end
		end else begin
			in_taken = 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: bus-level sequences turned into line samples
	// ------------------------------------------------------------------------
	logic gen_scl = 1'b1;
	logic gen_sda = 1'b1;
	int   samples_queued = 0;
	int   settings_applied = 0;

	// Mostly single samples; longer holds let the timeouts fire
	function automatic int hold_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Queue one line level, repeated holds extra times, random backend fields
	task automatic put(input logic scl, input logic sda, input int holds);
		line_sample_t s;
		repeat (holds + 1) begin
			s.scl         = scl;
			s.sda         = sda;
			s.byte_accept = ($urandom_range(0, 9) != 0);
			s.read_data   = BYTE_W'($urandom);
			sample_queue.push_back(s);
			samples_queued++;
		end
		gen_scl = scl;
		gen_sda = sda;
	endtask

	// SDA only moves while SCL is low; the bit ends with SCL high
	task automatic send_bit(input logic b);
		if (gen_scl)
			put(1'b0, gen_sda, hold_count());
		if (gen_sda != b)
			put(1'b0, b, hold_count());
		put(1'b1, b, hold_count());
	endtask

	task automatic send_byte(input logic [7:0] v);
		for (int i = 7; i >= 0; i--)
			send_bit(v[i]);
	endtask

	// Works from idle (START) and from inside a transfer (repeated START)
	task automatic send_start();
		if (!(gen_scl && gen_sda)) begin
			if (gen_scl)
				put(1'b0, gen_sda, 0);
			if (!gen_sda)
				put(1'b0, 1'b1, hold_count());
			put(1'b1, 1'b1, hold_count());
		end
		put(1'b1, 1'b0, hold_count());
	endtask

	task automatic send_stop();
		if (gen_scl)
			put(1'b0, gen_sda, 0);
		if (gen_sda)
			put(1'b0, 1'b0, hold_count());
		put(1'b1, 1'b0, hold_count());
		put(1'b1, 1'b1, 0);
	endtask

	// Mostly a configured address so that transfers go past the address byte
	function automatic logic [ADDR_W-1:0] pick_address();
		int n;
		n = (slots_used > CFG_SLOT_REGS) ? CFG_SLOT_REGS : int'(slots_used);
		if (n > 0 && $urandom_range(0, 3) != 0)
			return slot_addr[$urandom_range(0, n - 1)];
		return ADDR_W'($urandom);
	endfunction

	// One transfer: address, ACK slot, then write bytes or read bytes
	task automatic run_transfer();
		logic [ADDR_W-1:0] addr;
		logic              dir_read;
		int                nbytes;
		int                r;
		addr     = pick_address();
		dir_read = 1'($urandom_range(0, 1));
		nbytes   = $urandom_range(0, 4);
		send_start();
		send_byte({addr, dir_read});
		send_bit($urandom_range(0, 4) == 0);
		if (!dir_read) begin
			repeat (nbytes) begin
				send_byte(BYTE_W'($urandom));
				send_bit(1'($urandom_range(0, 1)));
			end
		end else begin
			for (int i = 0; i < nbytes; i++) begin
				// line level during target bits is arbitrary but stable under SCL high
				repeat (8)
					send_bit(1'($urandom_range(0, 1)));
				// master NACKs the last byte, and now and then an earlier one
				send_bit(i == nbytes - 1 || $urandom_range(0, 7) == 0);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 7)
			send_stop();
		else if (r < 9)
			;	// leave the bus held for a repeated START
		else
			put(gen_scl, gen_sda, $urandom_range(10, 70));
	endtask

	// START followed by a cut-off run of random bits
	task automatic run_broken();
		send_start();
		repeat ($urandom_range(1, 12))
			send_bit(1'($urandom_range(0, 1)));
		if ($urandom_range(0, 1))
			send_stop();
	endtask

	task automatic run_noise(input int n);
		repeat (n)
			put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), hold_count());
	endtask

	task automatic fill_random(input int target);
		int first;
		int r;
		first = samples_queued;
		while (samples_queued - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				run_transfer();
			else if (r < 88)
				run_broken();
			else
				run_noise($urandom_range(2, 12));
		end
		send_stop();
	endtask

	// ------------------------------------------------------------------------
	// Register writes, only while nothing is in flight
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			CFG_DEVICE_COUNT:   slots_used   = val[DEV_COUNT_W-1:0];
			CFG_ADDRESS_SLOT_0: slot_addr[0] = val[ADDR_W-1:0];
			CFG_ADDRESS_SLOT_1: slot_addr[1] = val[ADDR_W-1:0];
			CFG_ADDRESS_SLOT_2: slot_addr[2] = val[ADDR_W-1:0];
			CFG_ADDRESS_SLOT_3: slot_addr[3] = val[ADDR_W-1:0];
			CFG_STUCK_LOW:      stuck_limit  = val[LIMIT_W-1:0];
			CFG_NO_EDGE:        quiet_limit  = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int count, input logic [ADDR_W-1:0] a0,
			input logic [ADDR_W-1:0] a1, input logic [ADDR_W-1:0] a2,
			input logic [ADDR_W-1:0] a3, input logic [LIMIT_W-1:0] stuck,
			input logic [LIMIT_W-1:0] quiet);
		write_reg(CFG_DEVICE_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_ADDRESS_SLOT_0, CFG_DATA_W'(a0));
		write_reg(CFG_ADDRESS_SLOT_1, CFG_DATA_W'(a1));
		write_reg(CFG_ADDRESS_SLOT_2, CFG_DATA_W'(a2));
		write_reg(CFG_ADDRESS_SLOT_3, CFG_DATA_W'(a3));
		write_reg(CFG_STUCK_LOW, CFG_DATA_W'(stuck));
		write_reg(CFG_NO_EDGE, CFG_DATA_W'(quiet));
		settings_applied++;
	endtask

	// Hold until every queued sample is in and every result is out
	task automatic drain();
		while (sample_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		foreach (bus_seen[i]) begin
			bus_seen[i] = 0;
			dev_seen[i] = 0;
		end
		reset_engine_model();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: bus conditions with zero stuck limit and a tiny no-edge limit
		apply_setting(1, 7'h00, 7'h7F, 7'h00, 7'h00, 20'd0, 20'd2);
		put(1'b0, 1'b1, 0);		// idle: none of these four should register
		put(1'b0, 1'b0, 0);
		put(1'b1, 1'b0, 0);
		put(1'b1, 1'b1, 0);
		put(1'b1, 1'b0, 0);		// START
		put(1'b1, 1'b1, 0);		// STOP
		put(1'b1, 1'b0, 0);		// START
		put(1'b0, 1'b1, 0);		// SCL falls as SDA rises: just a clock edge
		put(1'b1, 1'b0, 0);		// SCL rises as SDA falls: repeated START
		put(1'b0, 1'b0, 0);
		put(1'b0, 1'b0, 0);		// both low and unchanged past a zero limit
		put(1'b0, 1'b1, 0);
		put(1'b1, 1'b1, 0);
		put(1'b1, 1'b0, 0);		// START
		put(1'b1, 1'b0, 3);		// unchanged past the no-edge limit
		put(1'b1, 1'b1, 0);
		drain();

		// Spare index must not disturb any register
		write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));

		// Single slot at address zero, stuck limit of one
		apply_setting(1, 7'h00, 7'h7F, 7'h2A, 7'h55, 20'd1, LIMIT_MAX);
		fill_random(220);
		drain();

		// All slots, address 127 twice, stuck timeout never reachable
		apply_setting(4, 7'h7F, 7'h00, 7'h50, 7'h7F, LIMIT_MAX, 20'd8);
		fill_random(220);
		drain();

		// Count above the slot total, duplicate addresses
		apply_setting(7, 7'h33, 7'h33, 7'h21, 7'h42, 20'd20, 20'd40);
		fill_random(220);
		drain();

		// No slots in use, timeouts at their reset values
		apply_setting(0, 7'h11, 7'h22, 7'h33, 7'h44, STUCK_LOW_RESET, NO_EDGE_RESET);
		fill_random(150);
		drain();

		apply_setting($urandom_range(1, 4), ADDR_W'($urandom), ADDR_W'($urandom),
			ADDR_W'($urandom), ADDR_W'($urandom), LIMIT_W'($urandom_range(2, 30)),
			LIMIT_W'($urandom_range(5, 60)));
		fill_random(270);
		drain();

		apply_setting(5, ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
			ADDR_W'($urandom), 20'd3, LIMIT_MAX - 1);
		fill_random(230);
		drain();

		$display("Checked %0d line samples under %0d register settings.",
			results_checked, settings_applied);
		$display("Bus: %0d start, %0d restart, %0d stop, %0d timeout; device: %0d begin, %0d rx, %0d fetch, %0d advance, %0d end.",
			bus_seen[BUS_START], bus_seen[BUS_RESTART], bus_seen[BUS_STOP],
			bus_seen[BUS_TIMEOUT], dev_seen[DEV_BEGIN], dev_seen[DEV_RECEIVE],
			dev_seen[DEV_FETCH], dev_seen[DEV_ADVANCE], dev_seen[DEV_END]);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
